[hw/rtl/tcle_pkg.sv]
// Shared types, codes and the set-1 scancode map for the text console line editor.
// No dependencies; every other file in hw/rtl refers to this package by scoped names.
`timescale 1ns / 1ps

package tcle_pkg;

    // Request types on the input channel
    localparam logic [1:0] REQ_PRINT = 2'd0;
    localparam logic [1:0] REQ_KEY   = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // Character and scancode constants
    localparam logic [7:0] KEY_ENTER     = 8'h1C;
    localparam logic [7:0] KEY_BACKSPACE = 8'h0E;
    localparam logic [7:0] CHAR_NEWLINE  = 8'h0A;
    localparam logic [7:0] CHAR_BLANK    = 8'h20;
    localparam logic [7:0] CHAR_NONE     = 8'h00;
    localparam logic [7:0] ATTR_RESET    = 8'h07;
    localparam int         KEY_RELEASE_BIT = 7;

    // Commands passed from the front to the back
    typedef enum logic [2:0] {
        OP_WRITE,
        OP_NEWLINE,
        OP_KEY,
        OP_BACKSPACE,
        OP_ENTER,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] ch;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_push_t;

    // Result event codes
    typedef enum logic [1:0] {
        EV_WRITE = 2'd0,
        EV_CLEAR = 2'd1,
        EV_LINE  = 2'd2
    } event_t;

    typedef struct packed {
        event_t      kind;
        logic [10:0] index;
        logic [7:0]  ch;
        logic [7:0]  attr;
        logic [6:0]  pos;
        logic        last;
    } result_t;

    // Set-1 make code to character; zero means unmapped
    function automatic logic [7:0] scancode_char(input logic [7:0] code);
        logic [7:0] ch;
        unique case (code)
            8'd1:  ch = 8'h1B;
            8'd2:  ch = 8'h31;
            8'd3:  ch = 8'h32;
            8'd4:  ch = 8'h33;
            8'd5:  ch = 8'h34;
            8'd6:  ch = 8'h35;
            8'd7:  ch = 8'h36;
            8'd8:  ch = 8'h37;
            8'd9:  ch = 8'h38;
            8'd10: ch = 8'h39;
            8'd11: ch = 8'h30;
            8'd12: ch = 8'h2D;
            8'd13: ch = 8'h3D;
            8'd14: ch = 8'h08;
            8'd15: ch = 8'h09;
            8'd16: ch = 8'h71;
            8'd17: ch = 8'h77;
            8'd18: ch = 8'h65;
            8'd19: ch = 8'h72;
            8'd20: ch = 8'h74;
            8'd21: ch = 8'h79;
            8'd22: ch = 8'h75;
            8'd23: ch = 8'h69;
            8'd24: ch = 8'h6F;
            8'd25: ch = 8'h70;
            8'd26: ch = 8'h5B;
            8'd27: ch = 8'h5D;
            8'd28: ch = 8'h0A;
            8'd30: ch = 8'h61;
            8'd31: ch = 8'h73;
            8'd32: ch = 8'h64;
            8'd33: ch = 8'h66;
            8'd34: ch = 8'h67;
            8'd35: ch = 8'h68;
            8'd36: ch = 8'h6A;
            8'd37: ch = 8'h6B;
            8'd38: ch = 8'h6C;
            8'd39: ch = 8'h3B;
            8'd40: ch = 8'h27;
            8'd41: ch = 8'h60;
            8'd43: ch = 8'h5C;
            8'd44: ch = 8'h7A;
            8'd45: ch = 8'h78;
            8'd46: ch = 8'h63;
            8'd47: ch = 8'h76;
            8'd48: ch = 8'h62;
            8'd49: ch = 8'h6E;
            8'd50: ch = 8'h6D;
            8'd51: ch = 8'h2C;
            8'd52: ch = 8'h2E;
            8'd53: ch = 8'h2F;
            8'd55: ch = 8'h2A;
            8'd57: ch = 8'h20;
            default: ch = CHAR_NONE;
        endcase
        return ch;
    endfunction

endpackage

[hw/rtl/tcle_front.sv]
// Front end: accepts input items and turns them into console commands.
// Depends on tcle_pkg; feeds tcle_queue.
`timescale 1ns / 1ps

module tcle_front (
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          req_type,
    input  logic [7:0]          data_byte,
    input  logic                q_full,
    output tcle_pkg::q_push_t   push
);

    logic            keep;
    tcle_pkg::cmd_t  cmd;
    logic [7:0]      mapped;

    assign in_ready = !q_full;
    assign mapped   = tcle_pkg::scancode_char(data_byte);

    // Items that can never produce a result or change state are dropped here
    always_comb
    begin
        keep    = 1'b0;
        cmd.op  = tcle_pkg::OP_CLEAR;
        cmd.ch  = data_byte;
        unique case (req_type)
            tcle_pkg::REQ_PRINT:
            begin
                if (data_byte == tcle_pkg::CHAR_NEWLINE)
                begin
                    keep   = 1'b1;
                    cmd.op = tcle_pkg::OP_NEWLINE;
                end
                else if (data_byte != tcle_pkg::CHAR_NONE)
                begin
                    keep   = 1'b1;
                    cmd.op = tcle_pkg::OP_WRITE;
                end
            end
            tcle_pkg::REQ_KEY:
            begin
                if (data_byte[tcle_pkg::KEY_RELEASE_BIT])
                begin
                    keep = 1'b0;
                end
                else if (data_byte == tcle_pkg::KEY_ENTER)
                begin
                    keep   = 1'b1;
                    cmd.op = tcle_pkg::OP_ENTER;
                end
                else if (data_byte == tcle_pkg::KEY_BACKSPACE)
                begin
                    keep   = 1'b1;
                    cmd.op = tcle_pkg::OP_BACKSPACE;
                end
                else if (mapped != tcle_pkg::CHAR_NONE)
                begin
                    keep   = 1'b1;
                    cmd.op = tcle_pkg::OP_KEY;
                    cmd.ch = mapped;
                end
            end
            tcle_pkg::REQ_CLEAR:
            begin
                keep   = 1'b1;
                cmd.op = tcle_pkg::OP_CLEAR;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign push.valid = in_valid && in_ready && keep;
    assign push.cmd   = cmd;

endmodule

[hw/rtl/tcle_queue.sv]
// Two-entry command queue between the front and back ends.
// Depends on tcle_pkg for the command types.
`timescale 1ns / 1ps

module tcle_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  tcle_pkg::q_push_t   push,
    input  logic                pop,
    output logic                full,
    output logic                head_valid,
    output tcle_pkg::cmd_t      head
);

    tcle_pkg::cmd_t mem [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    logic           do_push;
    logic           do_pop;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = mem[rd_ptr_reg];

    assign do_push = push.valid && !full;
    assign do_pop  = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push.cmd;
        end
    end

endmodule

[hw/rtl/tcle_back.sv]
// Back end: cursor, column and line length state, attribute register and result register.
// Depends on tcle_pkg; consumes commands from tcle_queue.
`timescale 1ns / 1ps

module tcle_back #(
    parameter int SCREEN_COLUMNS = 80,
    parameter int SCREEN_ROWS    = 25,
    parameter int LINE_CAPACITY  = 80
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [7:0]         cfg_wr_data,
    input  logic               q_valid,
    input  tcle_pkg::cmd_t     q_head,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output tcle_pkg::result_t  res
);

    localparam int CELLS = SCREEN_COLUMNS * SCREEN_ROWS;
    localparam int CW    = $clog2(CELLS);
    localparam int COLW  = $clog2(SCREEN_COLUMNS);
    localparam int LW    = $clog2(LINE_CAPACITY);

    localparam logic [CW:0]     CELLS_W   = (CW + 1)'(CELLS);
    localparam logic [CW:0]     COLS_W    = (CW + 1)'(SCREEN_COLUMNS);
    localparam logic [CW-1:0]   LAST_CELL = CW'(CELLS - 1);
    localparam logic [COLW-1:0] LAST_COL  = COLW'(SCREEN_COLUMNS - 1);
    localparam logic [LW-1:0]   LINE_FULL = LW'(LINE_CAPACITY - 1);

    logic [CW-1:0]     cursor_reg;
    logic [CW-1:0]     cursor_next;
    logic [COLW-1:0]   col_reg;
    logic [COLW-1:0]   col_next;
    logic [LW-1:0]     len_reg;
    logic [LW-1:0]     len_next;
    logic              pend_reg;
    logic              pend_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [7:0]        attr_reg;
    tcle_pkg::result_t res_reg;
    tcle_pkg::result_t res_next;
    tcle_pkg::result_t clear_res;

    logic              can_load;
    logic [CW:0]       cur_inc;
    logic              inc_end;
    logic [COLW-1:0]   col_inc;
    logic [CW:0]       row_sum;
    logic              row_end;
    logic [CW-1:0]     cur_dec;
    logic [COLW-1:0]   col_dec;
    logic [LW-1:0]     len_dec;

    assign can_load = !out_valid_reg || out_ready;

    // Next-cell, next-row and previous-cell arithmetic
    assign cur_inc = {1'b0, cursor_reg} + (CW + 1)'(1);
    assign inc_end = (cur_inc == CELLS_W);
    assign col_inc = (col_reg == LAST_COL) ? '0 : col_reg + COLW'(1);
    assign row_sum = {1'b0, cursor_reg} + (COLS_W - (CW + 1)'(col_reg));
    assign row_end = (row_sum >= CELLS_W);
    assign cur_dec = (cursor_reg == '0) ? LAST_CELL : cursor_reg - CW'(1);
    assign col_dec = (col_reg == '0) ? LAST_COL : col_reg - COLW'(1);
    assign len_dec = len_reg - LW'(1);

    always_comb
    begin
        clear_res       = '0;
        clear_res.kind  = tcle_pkg::EV_CLEAR;
        clear_res.last  = 1'b1;
    end

    always_comb
    begin
        cursor_next    = cursor_reg;
        col_next       = col_reg;
        len_next       = len_reg;
        pend_next      = pend_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !out_ready;
        q_pop          = 1'b0;

        if (can_load && pend_reg)
        begin
            // second result of a command that ran off the end of the screen
            res_next       = clear_res;
            out_valid_next = 1'b1;
            pend_next      = 1'b0;
        end
        else if (can_load && q_valid)
        begin
            q_pop = 1'b1;
            unique case (q_head.op) inside
                tcle_pkg::OP_WRITE, tcle_pkg::OP_KEY:
                begin
                    if (q_head.op == tcle_pkg::OP_WRITE || len_reg < LINE_FULL)
                    begin
                        res_next.kind  = tcle_pkg::EV_WRITE;
                        res_next.index = 11'(cursor_reg);
                        res_next.ch    = q_head.ch;
                        res_next.attr  = attr_reg;
                        res_next.pos   = (q_head.op == tcle_pkg::OP_KEY) ? 7'(len_reg) : 7'd0;
                        res_next.last  = !inc_end;
                        out_valid_next = 1'b1;
                        pend_next      = inc_end;
                        cursor_next    = inc_end ? '0 : cur_inc[CW-1:0];
                        col_next       = inc_end ? '0 : col_inc;
                        if (q_head.op == tcle_pkg::OP_KEY)
                        begin
                            len_next = len_reg + LW'(1);
                        end
                    end
                end
                tcle_pkg::OP_NEWLINE:
                begin
                    cursor_next = row_end ? '0 : row_sum[CW-1:0];
                    col_next    = '0;
                    if (row_end)
                    begin
                        res_next       = clear_res;
                        out_valid_next = 1'b1;
                    end
                end
                tcle_pkg::OP_ENTER:
                begin
                    res_next       = '0;
                    res_next.kind  = tcle_pkg::EV_LINE;
                    res_next.pos   = 7'(len_reg);
                    res_next.last  = !row_end;
                    out_valid_next = 1'b1;
                    pend_next      = row_end;
                    len_next       = '0;
                    cursor_next    = row_end ? '0 : row_sum[CW-1:0];
                    col_next       = '0;
                end
                tcle_pkg::OP_BACKSPACE:
                begin
                    if (len_reg != '0)
                    begin
                        len_next       = len_dec;
                        cursor_next    = cur_dec;
                        col_next       = col_dec;
                        res_next.kind  = tcle_pkg::EV_WRITE;
                        res_next.index = 11'(cur_dec);
                        res_next.ch    = tcle_pkg::CHAR_BLANK;
                        res_next.attr  = attr_reg;
                        res_next.pos   = 7'(len_dec);
                        res_next.last  = 1'b1;
                        out_valid_next = 1'b1;
                    end
                end
                tcle_pkg::OP_CLEAR:
                begin
                    cursor_next    = '0;
                    col_next       = '0;
                    res_next       = clear_res;
                    out_valid_next = 1'b1;
                end
                default:
                begin
                    q_pop = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg    <= '0;
            col_reg       <= '0;
            len_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            attr_reg      <= tcle_pkg::ATTR_RESET;
        end
        else
        begin
            cursor_reg    <= cursor_next;
            col_reg       <= col_next;
            len_reg       <= len_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                attr_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    // cursor stays on the screen
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, cursor_reg} < CELLS_W)
        else $error("cursor left the screen");

    // column tracker stays inside a row
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        (CW + 1)'(col_reg) < COLS_W)
        else $error("column out of range");

    // a pending clear always sits behind a held, non-final result
    a_pend_held: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (out_valid_reg && !res_reg.last))
        else $error("pending clear without a first result");

    // line length never exceeds the line capacity limit
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LINE_FULL)
        else $error("line length overflow");

    // no command leaves the queue while a clear is still owed
    a_no_pop_pend: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> !q_pop)
        else $error("command popped ahead of pending clear");

endmodule

[hw/rtl/text_console_line_editor.sv]
// Top level of the text console line editor: front classifier, command queue, back end.
// Depends on tcle_pkg, tcle_front, tcle_queue and tcle_back.
`timescale 1ns / 1ps
//
//  channel   dir  handshake               payload
//  -------   ---  ----------------------  ---------------------------------------------
//  input     in   in_valid / in_ready     req_type, data_byte
//  result    out  out_valid / out_ready   event_kind, cell_index, cell_char, cell_attr,
//                                         line_pos, last
//  config    in   cfg_wr_en (no wait)     cfg_wr_data -> text attribute
//
//  An item is taken every cycle while the two-entry command queue has room; the back end
//  retires one command per cycle while the result register can load; a command owing
//  a clear event too (write or echoed key at the last cell, enter on the last row) loads
//  it as a second result. An accepted item passes the queue, then the result register.
//  rst_n clears cursor, column, line length, queue and output valid; attribute resets to 7.
//  A stalled result register holds the back end; the queue keeps the front taking items.

module text_console_line_editor #(
    parameter int SCREEN_COLUMNS = 80,
    parameter int SCREEN_ROWS    = 25,
    parameter int LINE_CAPACITY  = 80
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    // input items
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [7:0]  data_byte,
    // result items
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  event_kind,
    output logic [10:0] cell_index,
    output logic [7:0]  cell_char,
    output logic [7:0]  cell_attr,
    output logic [6:0]  line_pos,
    output logic        last
);

    tcle_pkg::q_push_t  push;
    tcle_pkg::cmd_t     head;
    tcle_pkg::result_t  res;
    logic               q_full;
    logic               q_valid;
    logic               q_pop;

    // Front: decode request type and scancode, drop items with no effect
    tcle_front u_front (
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .data_byte (data_byte),
        .q_full    (q_full),
        .push      (push)
    );

    // Decoupling queue: lets the front keep accepting while the output stalls
    tcle_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_valid),
        .head       (head)
    );

    // Back: cursor/line state, end-of-screen handling, registered result
    tcle_back #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .SCREEN_ROWS    (SCREEN_ROWS),
        .LINE_CAPACITY  (LINE_CAPACITY)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_valid     (q_valid),
        .q_head      (head),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .res         (res)
    );

    assign event_kind = res.kind;
    assign cell_index = res.index;
    assign cell_char  = res.ch;
    assign cell_attr  = res.attr;
    assign line_pos   = res.pos;
    assign last       = res.last;

endmodule

[test/text_console_line_editor_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for text_console_line_editor: directed and random requests,
// each result checked against a cycle-free model of the console. Needs tcle_pkg and the RTL.

module text_console_line_editor_tb;

    // Screen geometry, matching the defaults of the block
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int LINE_CAP   = 80;
    localparam int CELL_COUNT = COLUMNS * ROWS;

    // Request code the block never uses; it has to be dropped
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam int FIRST_UNMAPPED = 60;
    localparam int MAX_WAIT       = 10;   // longest gap or stall drawn per item
    localparam int SETTLE_CYCLES  = 8;    // ignored items may still sit in the command queue
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_ITEMS    = 230;  // items sent per random phase

    // Set-1 make code to character, entry 0 first; zero means no character
    localparam logic [0:FIRST_UNMAPPED-1][7:0] KEY_CHARS = {
        8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
        8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
        8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00
    };

    logic        clk;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [7:0]  cfg_wr_data = 8'h00;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic [1:0]  req_type    = tcle_pkg::REQ_PRINT;
    logic [7:0]  data_byte   = 8'h00;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic [1:0]  event_kind;
    logic [10:0] cell_index;
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
    logic [6:0]  line_pos;
    logic        last;

    // Model of the console: cursor, typed line length and current attribute
    int unsigned console_cursor = 0;
    int unsigned typed_length   = 0;
    logic [7:0]  console_attr   = tcle_pkg::ATTR_RESET;

    // Results still owed by the block, oldest first
    tcle_pkg::result_t expected_events[$];
    // The newest result of the request being modeled; it gets last set when the request ends
    tcle_pkg::result_t held_event;
    bit          event_held = 1'b0;

    int          mismatch_count = 0;
    bit          steady_flow    = 1'b0; // both sides run without gaps or stalls

    text_console_line_editor i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .data_byte   (data_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .event_kind  (event_kind),
        .cell_index  (cell_index),
        .cell_char   (cell_char),
        .cell_attr   (cell_attr),
        .line_pos    (line_pos),
        .last        (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #5_000_000;
        $display("[text_console_line_editor] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Console model
    // ------------------------------------------------------------------

    function automatic void emit_event(input tcle_pkg::event_t kind, input int unsigned cell_num,
                                       input logic [7:0] ch, input logic [7:0] attr,
                                       input int unsigned pos);
        tcle_pkg::result_t ev;
        ev.kind  = kind;
        ev.index = cell_num[10:0];
        ev.ch    = ch;
        ev.attr  = attr;
        ev.pos   = pos[6:0];
        ev.last  = 1'b0;
        if (event_held)
            expected_events.push_back(held_event);
        held_event = ev;
        event_held = 1'b1;
    endfunction

    // Any advance onto the cell count clears the screen and homes the cursor
    function automatic void wrap_at_screen_end();
        if (console_cursor >= CELL_COUNT)
        begin
            console_cursor = 0;
            emit_event(tcle_pkg::EV_CLEAR, 0, tcle_pkg::CHAR_NONE, 8'h00, 0);
        end
    endfunction

    function automatic void put_char(input logic [7:0] ch, input int unsigned pos);
        emit_event(tcle_pkg::EV_WRITE, console_cursor, ch, console_attr, pos);
        console_cursor++;
        wrap_at_screen_end();
    endfunction

    function automatic void start_next_row();
        console_cursor += COLUMNS - (console_cursor % COLUMNS);
        wrap_at_screen_end();
    endfunction

    function automatic void model_request(input logic [1:0] kind, input logic [7:0] value);
        logic [7:0] ch;
        case (kind)
            tcle_pkg::REQ_PRINT:
            begin
                // a zero byte is a string terminator and does nothing
                if (value == tcle_pkg::CHAR_NEWLINE)
                    start_next_row();
                else if (value != tcle_pkg::CHAR_NONE)
                    put_char(value, 0);
            end
            tcle_pkg::REQ_KEY:
            begin
                if (value[tcle_pkg::KEY_RELEASE_BIT])
                begin
                    // break code
                end
                else if (value == tcle_pkg::KEY_ENTER)
                begin
                    emit_event(tcle_pkg::EV_LINE, 0, tcle_pkg::CHAR_NONE, 8'h00,
                               typed_length);
                    typed_length = 0;
                    start_next_row();
                end
                else if (value == tcle_pkg::KEY_BACKSPACE)
                begin
                    // ignored on an empty line; wraps from the top left to the last cell
                    if (typed_length > 0)
                    begin
                        typed_length--;
                        console_cursor = (console_cursor == 0) ? CELL_COUNT - 1
                                                               : console_cursor - 1;
                        emit_event(tcle_pkg::EV_WRITE, console_cursor, tcle_pkg::CHAR_BLANK,
                                   console_attr, typed_length);
                    end
                end
                else
                begin
                    ch = (value < FIRST_UNMAPPED) ? KEY_CHARS[value] : tcle_pkg::CHAR_NONE;
                    // a full line drops further keys
                    if (ch != tcle_pkg::CHAR_NONE && typed_length < LINE_CAP - 1)
                    begin
                        put_char(ch, typed_length);
                        typed_length++;
                    end
                end
            end
            tcle_pkg::REQ_CLEAR:
            begin
                // the typed line survives a clear
                console_cursor = 0;
                emit_event(tcle_pkg::EV_CLEAR, 0, tcle_pkg::CHAR_NONE, 8'h00, 0);
            end
            default:
            begin
            end
        endcase

        if (event_held)
        begin
            held_event.last = 1'b1;
            expected_events.push_back(held_event);
            event_held = 1'b0;
        end
    endfunction

    // Random make code that echoes a character
    function automatic logic [7:0] pick_echo_key();
        logic [7:0] code;
        do
            code = 8'($urandom_range(1, FIRST_UNMAPPED - 1));
        while (KEY_CHARS[code] == tcle_pkg::CHAR_NONE || code == tcle_pkg::KEY_ENTER ||
               code == tcle_pkg::KEY_BACKSPACE);
        return code;
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Called and returns at a rising edge. in_valid is left high after the item is
    // taken, so a back-to-back item keeps it high with a single assignment.
    task automatic send_request(input logic [1:0] kind, input logic [7:0] value);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        req_type  <= kind;
        data_byte <= value;
        model_request(kind, value);
        // ready is stable away from the rising edge; high at the falling edge means taken
        do
            @(negedge clk);
        while (!in_ready);
        @(posedge clk);
    endtask

    // Drop valid, wait for every owed result, then let ignored items drain out
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_events.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_attribute(input logic [7:0] value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        console_attr = value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic log_mismatch(input string what);
        mismatch_count++;
        $display("%0t ns: mismatch: %s", $time, what);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, field by field check against the oldest owed result
    // ------------------------------------------------------------------

    initial
    begin : result_monitor
        int                stall;
        tcle_pkg::result_t got;
        tcle_pkg::result_t want;
        @(posedge rst_n);
        forever
        begin
            stall = steady_flow ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(negedge clk);
            while (out_valid !== 1'b1);
            got.kind  = tcle_pkg::event_t'(event_kind);
            got.index = cell_index;
            got.ch    = cell_char;
            got.attr  = cell_attr;
            got.pos   = line_pos;
            got.last  = last;
            @(posedge clk);
            if (expected_events.size() == 0)
            begin
                log_mismatch($sformatf("unexpected result kind %0d cell %0d char %h pos %0d",
                                       got.kind, got.index, got.ch, got.pos));
            end
            else
            begin
                want = expected_events.pop_front();
                if (got.kind !== want.kind || got.index !== want.index ||
                    got.ch !== want.ch || got.attr !== want.attr ||
                    got.pos !== want.pos || got.last !== want.last)
                    log_mismatch($sformatf(
                        "got %0d/%0d/%h/%h/%0d/%b want %0d/%0d/%h/%h/%0d/%b %s",
                        got.kind, got.index, got.ch, got.attr, got.pos, got.last,
                        want.kind, want.index, want.ch, want.attr, want.pos, want.last,
                        "(kind/cell/char/attr/pos/last)"));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every request kind and the ignored cases, at the reset attribute
    task automatic test_basic_requests();
        send_request(tcle_pkg::REQ_PRINT, 8'h41);
        send_request(tcle_pkg::REQ_PRINT, tcle_pkg::CHAR_NONE);    // terminator, nothing
        send_request(tcle_pkg::REQ_PRINT, 8'hFF);
        send_request(tcle_pkg::REQ_PRINT, 8'h80);
        send_request(tcle_pkg::REQ_PRINT, 8'h7F);
        send_request(tcle_pkg::REQ_PRINT, tcle_pkg::CHAR_NEWLINE);
        send_request(tcle_pkg::REQ_KEY, 8'h1E);              // 'a'
        send_request(tcle_pkg::REQ_KEY, 8'h39);              // space bar
        send_request(tcle_pkg::REQ_KEY, 8'h01);              // escape echoes 0x1B
        send_request(tcle_pkg::REQ_KEY, 8'h3B);              // maps to nothing
        send_request(tcle_pkg::REQ_KEY, 8'd60);              // first code past the map
        send_request(tcle_pkg::REQ_KEY, 8'h7F);
        send_request(tcle_pkg::REQ_KEY, 8'h00);
        send_request(tcle_pkg::REQ_KEY, 8'h9E);              // break of 'a'
        send_request(tcle_pkg::REQ_KEY, 8'hFF);
        send_request(tcle_pkg::REQ_KEY, tcle_pkg::KEY_BACKSPACE);
        send_request(tcle_pkg::REQ_KEY, tcle_pkg::KEY_BACKSPACE);
        send_request(tcle_pkg::REQ_KEY, tcle_pkg::KEY_BACKSPACE);
        send_request(tcle_pkg::REQ_KEY, tcle_pkg::KEY_BACKSPACE);  // empty line, dropped
        send_request(tcle_pkg::REQ_KEY, 8'h10);
        send_request(tcle_pkg::REQ_KEY, tcle_pkg::KEY_ENTER);
        send_request(tcle_pkg::REQ_CLEAR, 8'hA5);
        send_request(REQ_UNUSED, 8'hFF);
    endtask

    task automatic test_attribute_extremes();
        write_attribute(8'h00);
        send_request(tcle_pkg::REQ_PRINT, 8'h01);
        send_request(tcle_pkg::REQ_KEY, 8'h2C);
        send_request(tcle_pkg::REQ_KEY, tcle_pkg::KEY_BACKSPACE);
        write_attribute(8'hFF);
        send_request(tcle_pkg::REQ_PRINT, 8'hFE);
        send_request(tcle_pkg::REQ_KEY, 8'h32);
        send_request(tcle_pkg::REQ_KEY, tcle_pkg::KEY_BACKSPACE);
    endtask

    // Backspace from the top left lands on the last cell, which sets up every kind of
    // advance off the end of the screen without filling it.
    task automatic test_screen_wrap();
        write_attribute(8'h5A);
        send_request(tcle_pkg::REQ_KEY, tcle_pkg::KEY_ENTER);      // empty the line
        // write at the last cell
        send_request(tcle_pkg::REQ_KEY, 8'h1E);
        send_request(tcle_pkg::REQ_CLEAR, 8'h00);
        send_request(tcle_pkg::REQ_KEY, tcle_pkg::KEY_BACKSPACE);
        send_request(tcle_pkg::REQ_PRINT, 8'h5A);
        // newline on the last row
        send_request(tcle_pkg::REQ_KEY, 8'h1F);
        send_request(tcle_pkg::REQ_CLEAR, 8'h00);
        send_request(tcle_pkg::REQ_KEY, tcle_pkg::KEY_BACKSPACE);
        send_request(tcle_pkg::REQ_PRINT, tcle_pkg::CHAR_NEWLINE);
        // echoed key at the last cell
        send_request(tcle_pkg::REQ_KEY, 8'h20);
        send_request(tcle_pkg::REQ_CLEAR, 8'h00);
        send_request(tcle_pkg::REQ_KEY, tcle_pkg::KEY_BACKSPACE);
        send_request(tcle_pkg::REQ_KEY, 8'h21);
        // enter on the last row
        send_request(tcle_pkg::REQ_KEY, 8'h22);
        send_request(tcle_pkg::REQ_CLEAR, 8'h00);
        send_request(tcle_pkg::REQ_KEY, tcle_pkg::KEY_BACKSPACE);
        send_request(tcle_pkg::REQ_KEY, tcle_pkg::KEY_ENTER);
    endtask

    // Type past capacity, then edit the full line and enter it
    task automatic test_full_line();
        write_attribute(8'($urandom));
        send_request(tcle_pkg::REQ_KEY, tcle_pkg::KEY_ENTER);
        repeat (LINE_CAP + 5)
            send_request(tcle_pkg::REQ_KEY, pick_echo_key());
        send_request(tcle_pkg::REQ_KEY, tcle_pkg::KEY_BACKSPACE);
        send_request(tcle_pkg::REQ_KEY, pick_echo_key());
        send_request(tcle_pkg::REQ_KEY, pick_echo_key());    // full again, dropped
        send_request(tcle_pkg::REQ_KEY, tcle_pkg::KEY_ENTER);
        send_request(tcle_pkg::REQ_KEY, tcle_pkg::KEY_BACKSPACE);
    endtask

    // Mostly typing sessions with random keys, some prints and clears, the rest noise
    task automatic send_random_request(input bit long_lines);
        int sel;
        int key_share;
        int enter_share;
        key_share   = long_lines ? 60 : 35;
        enter_share = long_lines ? 1 : 6;
        sel = $urandom_range(0, 99);
        if (sel < key_share)
            send_request(tcle_pkg::REQ_KEY, pick_echo_key());
        else if (sel < key_share + 10)
            send_request(tcle_pkg::REQ_KEY, tcle_pkg::KEY_BACKSPACE);
        else if (sel < key_share + 10 + enter_share)
            send_request(tcle_pkg::REQ_KEY, tcle_pkg::KEY_ENTER);
        else if (sel < 80)
            send_request(tcle_pkg::REQ_PRINT, 8'($urandom_range(1, 255)));
        else if (sel < 85)
            send_request(tcle_pkg::REQ_PRINT, tcle_pkg::CHAR_NEWLINE);
        else if (sel < 88)
            send_request(tcle_pkg::REQ_CLEAR, 8'($urandom));
        else if (sel < 93)
            send_request(tcle_pkg::REQ_KEY, {1'b1, 7'($urandom)});
        else if (sel < 97)
            send_request(tcle_pkg::REQ_KEY, 8'($urandom));
        else
            send_request(2'($urandom), 8'($urandom));
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:       write_attribute(8'h00);
                1:       write_attribute(8'hFF);
                default: write_attribute(8'($urandom));
            endcase
            steady_flow = (phase % 3 == 2);
            repeat (PHASE_ITEMS)
                send_random_request(phase % 2 == 1);
        end
        steady_flow = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_basic_requests();
        test_attribute_extremes();
        test_screen_wrap();
        test_full_line();
        test_random_traffic();

        // every owed result in, then a few more cycles to catch strays
        wait_idle();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("[text_console_line_editor] OK");
        else
            $display("[text_console_line_editor] ERROR");
        $finish;
    end

endmodule
